// ===== hdl/priority_lock_arbiter_assert.svh =====
// Assertion shorthands for the priority lock arbiter.
`ifndef PRIORITY_LOCK_ARBITER_ASSERT_SVH
`define PRIORITY_LOCK_ARBITER_ASSERT_SVH

// Checked only outside reset.
`define PLA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define PLA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/plk_pkg.sv =====
package plk_pkg;

  localparam int unsigned ID_FIELD_W    = 16;
  localparam int unsigned COUNT_FIELD_W = 7;

  typedef enum logic [1:0] {
    FUNC_REQUEST = 2'd0,
    FUNC_POLL    = 2'd1,
    FUNC_RELEASE = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_POP    = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
  } cell_ctrl_t;

  typedef struct packed {
    logic [1:0]            func;
    logic [ID_FIELD_W-1:0] requester_id;
  } in_item_t;

  typedef struct packed {
    logic                     granted;
    logic                     dropped;
    logic                     is_locked;
    logic [ID_FIELD_W-1:0]    holder_id;
    logic                     requester_holds;
    logic [COUNT_FIELD_W-1:0] waiting_count;
  } out_item_t;

endpackage

// ===== hdl/plk_cell.sv =====
module plk_cell #(
  parameter int unsigned ID_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  plk_pkg::cell_ctrl_t ctrl,
  input  logic [ID_WIDTH-1:0] ins_id,
  input  logic [ID_WIDTH-1:0] left_id,
  input  logic                left_valid,
  input  logic                left_stays,
  input  logic [ID_WIDTH-1:0] right_id,
  input  logic                right_valid,
  output logic [ID_WIDTH-1:0] id,
  output logic                valid,
  output logic                stays
);
  import plk_pkg::*;

  logic [ID_WIDTH-1:0] id_next;
  logic                valid_next;

  // Cells holding a strictly larger id keep their place on insert.
  assign stays = valid && (id > ins_id);

  always_comb begin
    id_next    = id;
    valid_next = valid;
    case (ctrl.op)
      CELL_INSERT: begin
        if (!stays) begin
          if (left_stays) begin
            id_next    = ins_id;
            valid_next = 1'b1;
          end else begin
            id_next    = left_id;
            valid_next = left_valid;
          end
        end
      end
      CELL_POP: begin
        id_next    = right_id;
        valid_next = right_valid;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    id <= id_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

// ===== hdl/priority_lock_arbiter.sv =====
// Priority lock arbiter: a single lock with a waiting queue sorted by id,
// largest id at the head.
// Input channel req (valid/ready) carries func and requester_id: request
// queues the id, poll takes the lock when it is free and the id is at the
// head (the head then leaves the queue), release frees the lock.
// Output channel rsp (valid/ready) returns one status item per input item:
// granted, dropped (request with the queue full), lock flag, holder id,
// whether the requester holds the lock, and the waiting count.
// The status item is registered: it is valid in the cycle after the
// input item is accepted. One item per cycle is sustained while rsp_ready
// stays high; each item is finished by the row of queue cells,
// which all compare against the new id and shift left or right together.
// The single output register sets the rate when the receiver stalls:
// req_ready drops while a status item waits untaken.
// Synchronous reset empties the queue, frees the lock and clears rsp_valid;
// the block takes items from the first cycle after reset.
module priority_lock_arbiter #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned ID_WIDTH    = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  plk_pkg::in_item_t  req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output plk_pkg::out_item_t rsp
);
  import plk_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                accept;
  logic [ID_WIDTH-1:0] id_in;
  logic [ID_WIDTH+ID_FIELD_W-1:0] id_ext;
  logic [ID_WIDTH+ID_FIELD_W-1:0] holder_ext;
  logic [CNT_W+COUNT_FIELD_W-1:0] count_ext;

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic                lock_held;
  logic                lock_held_next;
  logic [ID_WIDTH-1:0] holder;
  logic [ID_WIDTH-1:0] holder_next;
  logic                full;
  logic                grant;
  logic                granted_next;
  logic                dropped_next;
  cell_op_e            op;
  cell_ctrl_t          ctrl;
  out_item_t           rsp_next;

  logic [ID_WIDTH-1:0] cell_id [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_valid;
  logic [QUEUE_DEPTH-1:0] cell_stays;
  logic [QUEUE_DEPTH:0]   occ_plus;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  assign id_ext = {{ID_WIDTH{1'b0}}, req.requester_id};
  assign id_in  = id_ext[ID_WIDTH-1:0];

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign grant = !lock_held && (count != '0) && (cell_id[0] == id_in);

  always_comb begin
    count_next     = count;
    lock_held_next = lock_held;
    holder_next    = holder;
    granted_next   = 1'b0;
    dropped_next   = 1'b0;
    op             = CELL_HOLD;
    unique case (func_e'(req.func))
      FUNC_REQUEST: begin
        if (full) begin
          dropped_next = 1'b1;
        end else begin
          op         = CELL_INSERT;
          count_next = count + CNT_W'(1);
        end
      end
      FUNC_POLL: begin
        if (grant) begin
          op             = CELL_POP;
          granted_next   = 1'b1;
          count_next     = count - CNT_W'(1);
          lock_held_next = 1'b1;
          holder_next    = id_in;
        end
      end
      FUNC_RELEASE: begin
        lock_held_next = 1'b0;
        holder_next    = '0;
      end
      default: ;
    endcase
  end

  assign ctrl.op = accept ? op : CELL_HOLD;

  assign holder_ext = {{ID_FIELD_W{1'b0}}, holder_next};
  assign count_ext  = {{COUNT_FIELD_W{1'b0}}, count_next};

  always_comb begin
    rsp_next.granted         = granted_next;
    rsp_next.dropped         = dropped_next;
    rsp_next.is_locked       = lock_held_next;
    rsp_next.holder_id       = holder_ext[ID_FIELD_W-1:0];
    rsp_next.requester_holds = lock_held_next && (holder_next == id_in);
    rsp_next.waiting_count   = count_ext[COUNT_FIELD_W-1:0];
  end

  // Queue row: cell 0 is the head.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [ID_WIDTH-1:0] l_id;
    logic                l_valid;
    logic                l_stays;
    logic [ID_WIDTH-1:0] r_id;
    logic                r_valid;

    if (i == 0) begin : g_head
      assign l_id    = '0;
      assign l_valid = 1'b0;
      assign l_stays = 1'b1;
    end else begin : g_left
      assign l_id    = cell_id[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_stays = cell_stays[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_id    = '0;
      assign r_valid = 1'b0;
    end else begin : g_right
      assign r_id    = cell_id[i+1];
      assign r_valid = cell_valid[i+1];
    end

    plk_cell #(
      .ID_WIDTH(ID_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .ins_id     (id_in),
      .left_id    (l_id),
      .left_valid (l_valid),
      .left_stays (l_stays),
      .right_id   (r_id),
      .right_valid(r_valid),
      .id         (cell_id[i]),
      .valid      (cell_valid[i]),
      .stays      (cell_stays[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      lock_held <= 1'b0;
      holder    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        lock_held <= lock_held_next;
        holder    <= holder_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // Occupied cells form a prefix of the row.
  assign occ_plus = {1'b0, cell_valid} + {{QUEUE_DEPTH{1'b0}}, 1'b1};

  `include "priority_lock_arbiter_assert.svh"

  `PLA_ASSERT(a_count_range, count <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
  `PLA_ASSERT(a_prefix, $onehot(occ_plus), "occupied cells not contiguous from the head")
  `PLA_ASSERT(a_count_match, $countones(cell_valid) == 32'(count), "count disagrees with cells")
  `PLA_ASSERT(a_grant_locks, (accept && granted_next) |=> (lock_held && rsp.is_locked), "grant did not lock")
  `PLA_ASSERT(a_drop_full, (accept && dropped_next) |=> full, "request dropped with room left")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import plk_pkg::*;

  localparam int QDEPTH         = 64;
  localparam int LONG_HOLD      = 200;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_e;

  logic       clk;
  logic       rst;
  logic       req_valid;
  logic       req_ready;
  in_item_t   req;
  logic       rsp_valid;
  logic       rsp_ready;
  out_item_t  rsp;

  bit tx_jitter;
  bit rx_jitter;
  bit hold_now;
  int quiet_cycles;
  int sent;

  // Tracks the lock and its sorted wait queue; expected status items are
  // queued in acceptance order.
  class lock_scoreboard;
    logic [ID_FIELD_W-1:0] waiting [QDEPTH];
    int                    n_waiting;
    bit                    held;
    logic [ID_FIELD_W-1:0] owner;
    out_item_t             status_q[$];
    int                    failures;

    function new();
      foreach (waiting[i]) waiting[i] = '0;
      n_waiting = 0;
      held      = 1'b0;
      owner     = '0;
      failures  = 0;
    endfunction

    function out_item_t predict_status(in_item_t it);
      out_item_t             s;
      logic [ID_FIELD_W-1:0] id;
      int                    pos;
      int                    i;
      s  = '0;
      id = it.requester_id;
      case (func_e'(it.func))
        FUNC_REQUEST: begin
          if (n_waiting >= QDEPTH) begin
            s.dropped = 1'b1;
          end else begin
            // new id goes ahead of equal ones
            pos = 0;
            while (pos < n_waiting && waiting[pos] > id) pos++;
            for (i = n_waiting; i > pos; i--) waiting[i] = waiting[i-1];
            waiting[pos] = id;
            n_waiting++;
          end
        end
        FUNC_POLL: begin
          if (!held && n_waiting != 0 && waiting[0] == id) begin
            for (i = 0; i + 1 < n_waiting; i++) waiting[i] = waiting[i+1];
            waiting[n_waiting-1] = '0;
            n_waiting--;
            held      = 1'b1;
            owner     = id;
            s.granted = 1'b1;
          end
        end
        FUNC_RELEASE: begin
          held  = 1'b0;
          owner = '0;
        end
        default: ;
      endcase
      s.is_locked       = held;
      s.holder_id       = owner;
      s.requester_holds = held && (owner == id);
      s.waiting_count   = n_waiting[COUNT_FIELD_W-1:0];
      return s;
    endfunction

    function void take_item(in_item_t it);
      status_q.push_back(predict_status(it));
    endfunction

    function void check_status(out_item_t got);
      out_item_t want;
      bit        bad;
      if (status_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("status item with none expected: g=%0b d=%0b l=%0b h=%04h rh=%0b n=%0d",
                   got.granted, got.dropped, got.is_locked, got.holder_id,
                   got.requester_holds, got.waiting_count);
      end else begin
        want = status_q.pop_front();
        bad  = (got.granted !== want.granted) || (got.dropped !== want.dropped) ||
               (got.is_locked !== want.is_locked) || (got.holder_id !== want.holder_id) ||
               (got.requester_holds !== want.requester_holds) ||
               (got.waiting_count !== want.waiting_count);
        if (bad) begin
          failures++;
          if (failures <= 10)
            $display({"status mismatch: expected g=%0b d=%0b l=%0b h=%04h rh=%0b n=%0d,",
                      " got g=%0b d=%0b l=%0b h=%04h rh=%0b n=%0d"},
                     want.granted, want.dropped, want.is_locked, want.holder_id,
                     want.requester_holds, want.waiting_count,
                     got.granted, got.dropped, got.is_locked, got.holder_id,
                     got.requester_holds, got.waiting_count);
        end
      end
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    function logic [ID_FIELD_W-1:0] head_id();
      return waiting[0];
    endfunction
  endclass

  lock_scoreboard sb;

  priority_lock_arbiter #(
    .QUEUE_DEPTH(QDEPTH),
    .ID_WIDTH   (ID_FIELD_W)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // handshake monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) sb.take_item(req);
      if (rsp_valid && rsp_ready) sb.check_status(rsp);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("FAIL priority_lock_arbiter");
          $finish;
        end
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    rsp_ready = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      if (hold_now) begin
        rsp_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_now = 1'b0;
      end else if (rx_jitter && $urandom_range(0, 7) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      @(negedge clk);
    end
  end

  function automatic in_item_t mk(func_e f, logic [ID_FIELD_W-1:0] id);
    in_item_t it;
    it.func         = f;
    it.requester_id = id;
    return it;
  endfunction

  function automatic logic [ID_FIELD_W-1:0] pick_id();
    case ($urandom_range(0, 5))
      0:       return ID_FIELD_W'($urandom_range(0, 3));
      1:       return ID_FIELD_W'(16'hFFFF - $urandom_range(0, 3));
      default: return ID_FIELD_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Built at a falling edge after the previous item was taken, so the
  // tracked queue is current.
  function automatic in_item_t make_item(phase_e kind);
    in_item_t it;
    int       r;
    r               = $urandom_range(0, 99);
    it.requester_id = pick_id();
    case (kind)
      PH_FILL: begin
        if (r < 85) begin
          it.func = FUNC_REQUEST;
        end else if (r < 92) begin
          it.func         = FUNC_POLL;
          it.requester_id = sb.head_id();
        end else if (r < 97) begin
          it.func = FUNC_RELEASE;
        end else begin
          it.func = FUNC_NONE;
        end
      end
      PH_DRAIN: begin
        if (r < 90) begin
          if (sb.held) begin
            it.func = FUNC_RELEASE;
          end else begin
            it.func         = FUNC_POLL;
            it.requester_id = sb.head_id();
          end
        end else begin
          it.func = 2'($urandom_range(0, 3));
        end
      end
      default: begin
        it.func = 2'($urandom_range(0, 3));
        if (r < 50) it.requester_id = sb.head_id();
        else if (r >= 80 && sb.held) it.requester_id = sb.owner;
      end
    endcase
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(in_item_t it);
    if (tx_jitter && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    req       <= it;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  task automatic run_phase(phase_e kind, int len);
    repeat (len) begin
      send_item(make_item(kind));
      sent++;
    end
  endtask

  task automatic pause_until_drained();
    req_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    in_item_t directed[$];
    int       n_phase;
    rst          = 1'b1;
    req_valid    = 1'b0;
    req          = '0;
    tx_jitter    = 1'b0;
    rx_jitter    = 1'b0;
    hold_now     = 1'b0;
    quiet_cycles = 0;
    sent         = 0;
    sb           = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // poll on empty queue, release while free, unused selector
    directed.push_back(mk(FUNC_POLL,    16'h0005));
    directed.push_back(mk(FUNC_RELEASE, 16'h0000));
    directed.push_back(mk(FUNC_NONE,    16'hFFFF));
    // id zero, extremes, equal ids
    directed.push_back(mk(FUNC_REQUEST, 16'h0000));
    directed.push_back(mk(FUNC_REQUEST, 16'hFFFF));
    directed.push_back(mk(FUNC_REQUEST, 16'h8000));
    directed.push_back(mk(FUNC_REQUEST, 16'h8000));
    directed.push_back(mk(FUNC_REQUEST, 16'h0001));
    directed.push_back(mk(FUNC_POLL,    16'h8000));  // not at head
    directed.push_back(mk(FUNC_POLL,    16'hFFFF));  // head, lock free
    directed.push_back(mk(FUNC_POLL,    16'h8000));  // head but locked
    directed.push_back(mk(FUNC_REQUEST, 16'hAAAA));
    directed.push_back(mk(FUNC_RELEASE, 16'h1234));  // non-holder releases
    directed.push_back(mk(FUNC_RELEASE, 16'h0001));  // already free
    directed.push_back(mk(FUNC_POLL,    16'hAAAA));
    directed.push_back(mk(FUNC_NONE,    16'hAAAA));  // holder status only
    directed.push_back(mk(FUNC_RELEASE, 16'hAAAA));
    directed.push_back(mk(FUNC_POLL,    16'h8000));
    directed.push_back(mk(FUNC_RELEASE, 16'h5555));
    directed.push_back(mk(FUNC_POLL,    16'h8000));
    directed.push_back(mk(FUNC_RELEASE, 16'h8000));
    directed.push_back(mk(FUNC_REQUEST, 16'h5555));
    foreach (directed[i]) send_item(directed[i]);

    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
    // enough requests to fill the queue and hit drops
    run_phase(PH_FILL, 100);
    pause_until_drained();

    n_phase = 0;
    while (sent < 520) begin
      tx_jitter = ($urandom_range(0, 3) != 0);
      rx_jitter = ($urandom_range(0, 3) != 0);
      if (n_phase == 2) begin
        hold_now  = 1'b1;
        tx_jitter = 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        pause_until_drained();
      end
      run_phase(phase_e'($urandom_range(0, 2)), $urandom_range(20, 80));
      n_phase++;
    end

    tx_jitter = 1'b0;
    rx_jitter = 1'b0;
    run_phase(PH_MIX, 80);
    req_valid <= 1'b0;

    do @(negedge clk); while (sb.pending() != 0);
    repeat (4) @(negedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASS priority_lock_arbiter");
    end else begin
      $display("FAIL priority_lock_arbiter");
    end
    $finish;
  end

endmodule
